### src/trle_pkg.sv
package trle_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_HAS_ALPHA   = 8'd0;
    localparam logic [7:0] REG_RLE         = 8'd1;
    localparam logic [7:0] REG_PIXEL_TOTAL = 8'd2;

    // reset values of the configuration registers
    localparam logic        HAS_ALPHA_RST   = 1'b0;
    localparam logic        RLE_RST         = 1'b1;
    localparam logic [31:0] PIXEL_TOTAL_RST = 32'd1;

    // last byte index of a pixel for three and four byte pixels
    localparam logic [1:0] LAST_IDX_BGR  = 2'd2;
    localparam logic [1:0] LAST_IDX_BGRA = 2'd3;

    typedef struct packed {
        logic        has_alpha;
        logic        run_length_coded;
        logic [31:0] pixel_total;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       image_last;
    } pixel_t;

endpackage

### src/tga_rle_pixel_decoder.sv
// pixel path: the last byte of a pixel passes the input register and then the result register
// throughput: one byte per cycle while m_ready is high, set by the single decode stage
// between input and result registers; one pixel word per three or four pixel bytes
// reset: aresetn synchronous active low; clears the decode state, empties both
// registers and sets has_alpha 0, run_length_coded 1, pixel_total 1
module tga_rle_pixel_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic [7:0]  m_repeat_count,
    output logic        m_image_last
);

    trle_pkg::cfg_t   cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    trle_pkg::pixel_t out_reg;

    logic             fire;
    logic             emit;
    trle_pkg::pixel_t pixel;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.has_alpha        <= trle_pkg::HAS_ALPHA_RST;
            cfg_reg.run_length_coded <= trle_pkg::RLE_RST;
            cfg_reg.pixel_total      <= trle_pkg::PIXEL_TOTAL_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                trle_pkg::REG_HAS_ALPHA:   cfg_reg.has_alpha        <= cfg_data[0];
                trle_pkg::REG_RLE:         cfg_reg.run_length_coded <= cfg_data[0];
                trle_pkg::REG_PIXEL_TOTAL: cfg_reg.pixel_total      <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode stage advances when the result register can take a word
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    trle_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .emit      (emit),
        .pixel     (pixel)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_reg <= pixel;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_red          = out_reg.red;
    assign m_green        = out_reg.green;
    assign m_blue         = out_reg.blue;
    assign m_alpha        = out_reg.alpha;
    assign m_repeat_count = out_reg.repeat_count;
    assign m_image_last   = out_reg.image_last;

endmodule

### src/trle_core.sv
module trle_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic [7:0]            data_byte,
    input  trle_pkg::cfg_t        cfg,
    output logic                  emit,
    output trle_pkg::pixel_t      pixel
);

    logic        expect_header_reg, expect_header_next;
    logic        is_run_reg, is_run_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  bip_reg, bip_next;
    logic [23:0] hold_reg, hold_next;
    logic [31:0] done_reg, done_next;

    logic [1:0]  last_idx;
    logic        total_gt;
    logic [31:0] remaining;
    logic        rem_small;
    logic [7:0]  left_eff;
    logic [7:0]  count_raw;
    logic        clip;
    logic        img_done;

    // remaining pixels of the image and clipping of the count
    always_comb begin
        last_idx  = cfg.has_alpha ? trle_pkg::LAST_IDX_BGRA : trle_pkg::LAST_IDX_BGR;
        total_gt  = cfg.pixel_total > done_reg;
        remaining = total_gt ? (cfg.pixel_total - done_reg) : 32'd1;
        rem_small = (remaining[31:8] == 24'd0);
        left_eff  = (left_reg == 8'd0) ? 8'd1 : left_reg;
        count_raw = (cfg.run_length_coded && is_run_reg) ? left_eff : 8'd1;
        clip      = rem_small && (count_raw > remaining[7:0]);
        img_done  = rem_small && (count_raw >= remaining[7:0]);
    end

    // per byte decode
    always_comb begin
        expect_header_next = expect_header_reg;
        is_run_next        = is_run_reg;
        left_next          = left_reg;
        bip_next           = bip_reg;
        hold_next          = hold_reg;
        done_next          = done_reg;
        emit               = 1'b0;

        pixel.blue         = hold_reg[7:0];
        pixel.green        = hold_reg[15:8];
        pixel.red          = cfg.has_alpha ? hold_reg[23:16] : data_byte;
        pixel.alpha        = cfg.has_alpha ? data_byte : 8'd0;
        pixel.repeat_count = clip ? remaining[7:0] : count_raw;
        pixel.image_last   = img_done;

        if (cfg.run_length_coded && expect_header_reg) begin
            // packet header
            is_run_next        = data_byte[7];
            left_next          = {1'b0, data_byte[6:0]} + 8'd1;
            expect_header_next = 1'b0;
            bip_next           = 2'd0;
        end else if (bip_reg < last_idx) begin
            // collect a colour byte
            case (bip_reg)
                2'd0:    hold_next[7:0]   = data_byte;
                2'd1:    hold_next[15:8]  = data_byte;
                2'd2:    hold_next[23:16] = data_byte;
                default: ;
            endcase
            bip_next = bip_reg + 2'd1;
        end else begin
            // last byte of a pixel
            emit     = 1'b1;
            bip_next = 2'd0;
            if (cfg.run_length_coded) begin
                if (is_run_reg) begin
                    expect_header_next = 1'b1;
                    left_next          = 8'd0;
                end else begin
                    left_next = left_eff - 8'd1;
                    if (left_eff == 8'd1) begin
                        expect_header_next = 1'b1;
                    end
                end
            end
            if (img_done) begin
                expect_header_next = 1'b1;
                is_run_next        = 1'b0;
                left_next          = 8'd0;
                bip_next           = 2'd0;
                hold_next          = 24'd0;
                done_next          = 32'd0;
            end else begin
                done_next = done_reg + {24'd0, count_raw};
            end
        end
    end

    // decode state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_header_reg <= 1'b1;
            is_run_reg        <= 1'b0;
            left_reg          <= 8'd0;
            bip_reg           <= 2'd0;
            hold_reg          <= 24'd0;
            done_reg          <= 32'd0;
        end else if (fire) begin
            expect_header_reg <= expect_header_next;
            is_run_reg        <= is_run_next;
            left_reg          <= left_next;
            bip_reg           <= bip_next;
            hold_reg          <= hold_next;
            done_reg          <= done_next;
        end
    end

`ifndef SYNTH
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit |-> pixel.repeat_count != 8'd0)
        else $error("zero repeat count emitted");

    a_image_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit && pixel.image_last |=> done_reg == 32'd0 && expect_header_reg)
        else $error("state not cleared at image end");

    a_run_ends_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit && cfg.run_length_coded && is_run_reg |=> expect_header_reg)
        else $error("run packet did not return to header");

    a_done_below_total: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && emit && !pixel.image_last |=> done_reg < cfg.pixel_total)
        else $error("pixel count reached total without image end");
`endif

endmodule
